/* sv/assert_macros.svh */
// Assertion macros shared by the receiver RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every rising clock edge outside reset.
`define HKR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define HKR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HKR_ASSERT(lbl, clk, rstn, prop, msg)
`define HKR_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* sv/hkr_pkg.sv */
// Types and constants of the HK frame / AT line receiver.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package hkr_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 9;
  localparam int MODE_W = 3;
  localparam int LEN_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 3'd0,
    MODE_H_SEEN = 3'd1,
    MODE_BODY   = 3'd2,
    MODE_CR     = 3'd3,
    MODE_AT     = 3'd4
  } mode_t;

  localparam logic [BYTE_W-1:0] CH_H  = 8'h48;
  localparam logic [BYTE_W-1:0] CH_K  = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  localparam logic [IDX_W-1:0] LEN_HI_POS   = 9'd54;
  localparam logic [IDX_W-1:0] LEN_LO_POS   = 9'd55;
  localparam logic [IDX_W:0]   HEADER_BYTES = 10'd60;

  localparam logic             TGT_FRAME    = 1'b0;
  localparam logic             TGT_AT       = 1'b1;

endpackage

/* sv/hkr_in_if.sv */
// Input channel: one received serial byte per request.
// Depends on hkr_pkg for the field width.
`timescale 1ns / 1ps
interface hkr_in_if;
  logic                         valid;
  logic                         ready;
  logic [hkr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/hkr_out_if.sv */
// Result channel: buffer write command and frame status per request.
// Depends on hkr_pkg for the field widths.
`timescale 1ns / 1ps
interface hkr_out_if;
  logic                         valid;
  logic                         ready;
  logic [hkr_pkg::MODE_W-1:0]   mode;
  logic                         wr_en;
  logic                         wr_target;
  logic [hkr_pkg::IDX_W-1:0]    wr_index;
  logic [hkr_pkg::BYTE_W-1:0]   wr_data;
  logic                         frame_done;
  logic [hkr_pkg::LEN_W-1:0]    data_length;
  logic                         abort;

  modport source (output valid, output mode, output wr_en, output wr_target,
                  output wr_index, output wr_data, output frame_done,
                  output data_length, output abort, input ready);
  modport sink   (input valid, input mode, input wr_en, input wr_target,
                  input wr_index, input wr_data, input frame_done,
                  input data_length, input abort, output ready);
endinterface

/* sv/hk_frame_and_at_line_receiver_top.sv */
// HK frame / AT line receiver, top level.
// Depends on hkr_pkg, hkr_in_if, hkr_out_if and assert_macros.svh.
//
// in_chan carries one received serial byte per request (valid/ready).
// out_chan returns one result per byte: a write command (wr_en, wr_target,
// wr_index, wr_data) for the external frame or AT line buffer, the mode
// after the byte, the held payload length, a frame_done pulse and an abort
// flag (consumer clears the heads of both buffers).
// A frame opens with 'H','K'; bytes 54/55 carry a big-endian length and the
// frame closes at length+60 bytes. CR,LF opens an AT line stored below AT_LIMIT.
// Pipeline: input register then result register. Throughput one byte per
// cycle while out_chan.ready is high; the only loop is the position/mode/
// length update, one compare-and-increment per byte.
// Reset (rst_n, synchronous, active low) clears position, mode and length
// and empties both registers.
// Stall: with out_chan.ready low the held result freezes the receiver state;
// an empty input register still takes one byte, then in_chan.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hk_frame_and_at_line_receiver_top #(
  parameter int FRAME_LIMIT = 300,
  parameter int AT_LIMIT    = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  hkr_in_if.sink        in_chan,
  hkr_out_if.source     out_chan
);

  localparam int IW = hkr_pkg::IDX_W;
  localparam logic [IW:0] FRAME_LIM_C = (IW+1)'(FRAME_LIMIT);
  localparam logic [IW:0] AT_LIM_C    = (IW+1)'(AT_LIMIT);

  // pipeline control
  logic inp_valid_r;
  logic [hkr_pkg::BYTE_W-1:0] inp_byte_r;
  logic res_valid_r;
  logic adv;
  logic inp_take;

  assign adv          = !res_valid_r || out_chan.ready;
  assign inp_take     = inp_valid_r && adv;
  assign in_chan.ready = !inp_valid_r || adv;

  // receiver state
  logic [IW-1:0]               pos_r, pos_nxt;
  hkr_pkg::mode_t              mode_r, mode_nxt;
  logic [hkr_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [hkr_pkg::BYTE_W-1:0]  hi_r, hi_nxt;

  // per-byte outputs
  logic                        wr_en_c, tgt_c, done_c, abort_c;
  logic [IW-1:0]               idx_c;
  logic [IW:0]                 pos_inc;
  logic [IW:0]                 at_pos;
  logic [hkr_pkg::LEN_W:0]     len_end;

  assign pos_inc = {1'b0, pos_r} + (IW+1)'(1);
  assign len_end = {1'b0, len_nxt} + (hkr_pkg::LEN_W+1)'(hkr_pkg::HEADER_BYTES);

  always_comb begin
    pos_nxt  = pos_r;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    hi_nxt   = hi_r;
    wr_en_c  = 1'b0;
    tgt_c    = hkr_pkg::TGT_FRAME;
    idx_c    = '0;
    done_c   = 1'b0;
    abort_c  = 1'b0;
    at_pos   = {1'b0, pos_r};
    if (pos_r == '0) begin
      // junk before a header start is dropped silently
      if (inp_byte_r == hkr_pkg::CH_H) begin
        wr_en_c  = 1'b1;
        mode_nxt = hkr_pkg::MODE_H_SEEN;
        pos_nxt  = IW'(1);
      end else if (inp_byte_r == hkr_pkg::CH_CR) begin
        wr_en_c  = 1'b1;
        tgt_c    = hkr_pkg::TGT_AT;
        mode_nxt = hkr_pkg::MODE_CR;
        pos_nxt  = IW'(1);
      end
    end else if (pos_r == IW'(1)) begin
      if (inp_byte_r == hkr_pkg::CH_K && mode_r == hkr_pkg::MODE_H_SEEN) begin
        wr_en_c  = 1'b1;
        idx_c    = IW'(1);
        mode_nxt = hkr_pkg::MODE_BODY;
        pos_nxt  = IW'(2);
      end else if (inp_byte_r == hkr_pkg::CH_LF && mode_r == hkr_pkg::MODE_CR) begin
        wr_en_c  = 1'b1;
        tgt_c    = hkr_pkg::TGT_AT;
        idx_c    = IW'(1);
        mode_nxt = hkr_pkg::MODE_AT;
        pos_nxt  = IW'(2);
      end else begin
        pos_nxt = '0;
        abort_c = 1'b1;
      end
    end else if (mode_r == hkr_pkg::MODE_BODY) begin
      wr_en_c = 1'b1;
      idx_c   = pos_r;
      if (pos_r == hkr_pkg::LEN_HI_POS) hi_nxt = inp_byte_r;
      if (pos_r == hkr_pkg::LEN_LO_POS) len_nxt = {hi_r, inp_byte_r};
      pos_nxt = pos_inc[IW-1:0];
      // end-of-frame check only past the fixed header
      if (pos_inc > hkr_pkg::HEADER_BYTES) begin
        if ({{(hkr_pkg::LEN_W-IW){1'b0}}, pos_inc} >= len_end) begin
          done_c  = 1'b1;
          pos_nxt = '0;
        end else if (pos_inc >= FRAME_LIM_C) begin
          pos_nxt = '0;   // overrun wraps without done
        end
      end
    end else if (mode_r == hkr_pkg::MODE_AT) begin
      if ({1'b0, pos_r} < AT_LIM_C) begin
        wr_en_c = 1'b1;
        tgt_c   = hkr_pkg::TGT_AT;
        idx_c   = pos_r;
        at_pos  = pos_inc;
      end
      pos_nxt = (at_pos >= AT_LIM_C) ? '0 : at_pos[IW-1:0];
    end else begin
      pos_nxt = '0;
      abort_c = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      inp_valid_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      inp_byte_r <= in_chan.rx_byte;
    end
  end

  // receiver state, advanced once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= hkr_pkg::MODE_NONE;
      len_r  <= '0;
      hi_r   <= '0;
    end else if (inp_take) begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      hi_r   <= hi_nxt;
    end
  end

  // result register
  logic [hkr_pkg::MODE_W-1:0] res_mode_r;
  logic                       res_wr_en_r, res_tgt_r, res_done_r, res_abort_r;
  logic [IW-1:0]              res_idx_r;
  logic [hkr_pkg::BYTE_W-1:0] res_data_r;
  logic [hkr_pkg::LEN_W-1:0]  res_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= inp_valid_r;
    end
    if (inp_take) begin
      res_mode_r  <= mode_nxt;
      res_wr_en_r <= wr_en_c;
      res_tgt_r   <= wr_en_c ? tgt_c : 1'b0;
      res_idx_r   <= wr_en_c ? idx_c : '0;
      res_data_r  <= wr_en_c ? inp_byte_r : '0;
      res_done_r  <= done_c;
      res_len_r   <= len_nxt;
      res_abort_r <= abort_c;
    end
  end

  assign out_chan.valid       = res_valid_r;
  assign out_chan.mode        = res_mode_r;
  assign out_chan.wr_en       = res_wr_en_r;
  assign out_chan.wr_target   = res_tgt_r;
  assign out_chan.wr_index    = res_idx_r;
  assign out_chan.wr_data     = res_data_r;
  assign out_chan.frame_done  = res_done_r;
  assign out_chan.data_length = res_len_r;
  assign out_chan.abort       = res_abort_r;

  // terms used by the checks
  logic take_done, take_abort, res_stall, done_frame_ok, pos_bad;

  assign take_done     = inp_take && done_c;
  assign take_abort    = inp_take && abort_c;
  assign res_stall     = res_valid_r && !out_chan.ready;
  assign done_frame_ok = wr_en_c && (tgt_c == hkr_pkg::TGT_FRAME) &&
                         (mode_r == hkr_pkg::MODE_BODY);
  // AT lines are bounded by the line limit, everything else by the frame limit
  assign pos_bad = (mode_r == hkr_pkg::MODE_AT) ? ({1'b0, pos_r} > AT_LIM_C) :
                                                  ({1'b0, pos_r} >= FRAME_LIM_C);

  // checks
  `HKR_ASSERT(a_done_is_frame_write, clk, rst_n, take_done |-> done_frame_ok, "stray frame_done")
  `HKR_NEVER(a_abort_no_write, clk, rst_n, take_abort && wr_en_c, "abort with a write")
  `HKR_ASSERT(a_abort_clears_pos, clk, rst_n, take_abort |=> (pos_r == '0), "abort kept position")
  `HKR_ASSERT(a_stall_holds_state, clk, rst_n, res_stall |=> $stable({pos_r, len_r}), "stall moved state")
  `HKR_NEVER(a_pos_in_range, clk, rst_n, pos_bad, "position out of range")

endmodule
